[hdl/integral_image_stream_macros.svh]
// ----------------------------------------------------------------------------
// Integral image stream assertion macros
// Concurrent checks used by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGRAL_IMAGE_STREAM_MACROS_SVH
`define INTEGRAL_IMAGE_STREAM_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integral image stream: check failed");

// next-cycle implication
`define IIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integral image stream: check failed");

`else

`define IIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hdl/iis_pkg.sv]
// ----------------------------------------------------------------------------
// Integral image stream package
// Shared widths, register indexes, defaults and the dimension clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iis_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 28;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int DIM_CMP_W   = 14;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // control between the front end and the line store
    typedef struct packed {
        logic load;     // item transfer into the sum stage
        logic advance;  // sum stage hands its item to the output register
    } iis_ctl_t;

    // last index of a dimension: zero reads as one, large values clamp to the maximum
    function automatic logic [DIM_CMP_W-1:0] dim_last(
        input logic [CFG_W-1:0] v,
        input int unsigned      maxv
    );
        logic [DIM_CMP_W-1:0] ext;
        ext = DIM_CMP_W'(v);
        if (v == '0)
            return '0;
        if (ext > DIM_CMP_W'(maxv))
            return DIM_CMP_W'(maxv - 1);
        return ext - DIM_CMP_W'(1);
    endfunction

endpackage

[hdl/iis_line_store.sv]
// ----------------------------------------------------------------------------
// Integral image line store
// Holds the previous row's integral values; reads at transfer into a register,
// adds the row sum and writes the result back to the same column on advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iis_line_store #(
    parameter int MAX_WIDTH = iis_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH),
    parameter int ROW_SUM_W = 18
) (
    input  logic                     clk,
    input  iis_pkg::iis_ctl_t        ctl,
    input  logic [COL_W-1:0]         col,
    input  logic                     first_row,
    input  logic [ROW_SUM_W-1:0]     row_sum,
    input  logic                     last,
    output logic [iis_pkg::SUM_W-1:0] sum,
    output logic                     sum_last
);

    logic [iis_pkg::SUM_W-1:0] mem [MAX_WIDTH];

    logic [iis_pkg::SUM_W-1:0] rd_data_reg;
    logic [iis_pkg::SUM_W-1:0] fwd_data_reg;
    logic                      fwd_reg;
    logic [COL_W-1:0]          col_reg;
    logic                      first_row_reg;
    logic [ROW_SUM_W-1:0]      row_sum_reg;
    logic                      last_reg;
    logic [iis_pkg::SUM_W-1:0] above;

    // the item ahead writes the entry we read this cycle when the width is one column
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rd_data_reg   <= mem[col];
            fwd_reg       <= ctl.advance && (col == col_reg);
            fwd_data_reg  <= sum;
            col_reg       <= col;
            first_row_reg <= first_row;
            row_sum_reg   <= row_sum;
            last_reg      <= last;
        end
        if (ctl.advance)
            mem[col_reg] <= sum;
    end

    always_comb
    begin
        if (first_row_reg)
            above = '0;
        else if (fwd_reg)
            above = fwd_data_reg;
        else
            above = rd_data_reg;
    end

    assign sum      = above + iis_pkg::SUM_W'(row_sum_reg);
    assign sum_last = last_reg;

endmodule

[hdl/integral_image_stream.sv]
// ----------------------------------------------------------------------------
// Integral image stream
// Summed-area table of an 8-bit raster pixel stream with a one-row line store.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/pixel_value in raster order; in_stall holds the
//   source. Each pixel yields one result on out_valid/area_sum/frame_last,
//   frame_last marking the final pixel of the frame; out_stall holds it.
//   frame_width and frame_height are written on the cfg channel (index 0 and
//   1, always ready) while no pixel is in flight; 0 acts as 1 and values
//   above the maximum act as the maximum.
// Pipeline: the line store is read at the input transfer into the sum stage;
//   the sum stage adds and writes back as it hands its result to the output
//   register, which drives out_valid.
// Throughput: 1 pixel per cycle unless the output stalls, set by the single
//   read and write ports of the line store; one-column rows use forwarding.
// Reset: counters and row sum clear, dimensions return to 640 x 480, the
//   pipeline empties. The line store is not cleared; the first row never
//   reads it.
// Stall: a stalled result keeps the output register; one more pixel is taken
//   into the sum stage, then in_stall rises until the result leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integral_image_stream_macros.svh"

module integral_image_stream #(
    parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [iis_pkg::PIX_W-1:0]         pixel_value,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [iis_pkg::SUM_W-1:0]         area_sum,
    output logic                              frame_last,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iis_pkg::CFG_W-1:0]         cfg_data
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int ROW_SUM_W = $clog2(MAX_WIDTH * ((1 << iis_pkg::PIX_W) - 1) + 1);

    localparam logic [COL_W-1:0] W_LAST_RST =
        COL_W'(iis_pkg::dim_last(iis_pkg::RST_FRAME_WIDTH, MAX_WIDTH));
    localparam logic [ROW_W-1:0] H_LAST_RST =
        ROW_W'(iis_pkg::dim_last(iis_pkg::RST_FRAME_HEIGHT, MAX_HEIGHT));

    logic [COL_W-1:0]          w_last_reg, w_last_next;
    logic [ROW_W-1:0]          h_last_reg, h_last_next;
    logic [COL_W-1:0]          col_reg, col_next;
    logic [ROW_W-1:0]          row_reg, row_next;
    logic [ROW_SUM_W-1:0]      row_sum_reg, row_sum_next;
    logic                      s1_valid_reg, s1_valid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [iis_pkg::SUM_W-1:0] area_sum_reg;
    logic                      frame_last_reg;

    logic                      in_xfer;
    logic                      s1_adv;
    logic                      row_end;
    logic                      frame_end;
    logic [iis_pkg::SUM_W-1:0] sum;
    logic                      sum_last;
    iis_pkg::iis_ctl_t         ctl;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign ctl.load    = in_xfer;
    assign ctl.advance = s1_adv;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                iis_pkg::REG_FRAME_WIDTH:
                    w_last_next = COL_W'(iis_pkg::dim_last(cfg_data, MAX_WIDTH));
                iis_pkg::REG_FRAME_HEIGHT:
                    h_last_next = ROW_W'(iis_pkg::dim_last(cfg_data, MAX_HEIGHT));
                default:
                begin
                    w_last_next = w_last_reg;
                    h_last_next = h_last_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // raster counters and running row sum
    // ------------------------------------------------------------------
    assign row_end   = (col_reg >= w_last_reg);
    assign frame_end = row_end && (row_reg >= h_last_reg);

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        row_sum_next = row_sum_reg;
        if (in_xfer)
        begin
            // restart the row sum at column zero
            if (col_reg == '0)
                row_sum_next = ROW_SUM_W'(pixel_value);
            else
                row_sum_next = row_sum_reg + ROW_SUM_W'(pixel_value);

            if (row_end)
            begin
                col_next = '0;
                if (frame_end)
                    row_next = '0;
                else
                    row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline valids
    // ------------------------------------------------------------------
    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg    <= W_LAST_RST;
            h_last_reg    <= H_LAST_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            row_sum_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_last_reg    <= w_last_next;
            h_last_reg    <= h_last_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_sum_reg   <= row_sum_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            area_sum_reg   <= sum;
            frame_last_reg <= sum_last;
        end
    end

    // ------------------------------------------------------------------
    // line store and final add
    // ------------------------------------------------------------------
    iis_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .ROW_SUM_W (ROW_SUM_W)
    ) u_line_store (
        .clk       (clk),
        .ctl       (ctl),
        .col       (col_reg),
        .first_row (row_reg == '0),
        .row_sum   (row_sum_next),
        .last      (frame_end),
        .sum       (sum),
        .sum_last  (sum_last)
    );

    assign out_valid  = out_valid_reg;
    assign area_sum   = area_sum_reg;
    assign frame_last = frame_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `IIS_ASSERT_IMP(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg)
    `IIS_ASSERT_NXT(a_xfer_fills_stage, clk, rst_n, in_xfer, s1_valid_reg)
    `IIS_ASSERT_NXT(a_adv_fills_output, clk, rst_n, s1_adv, out_valid_reg)
    `IIS_ASSERT_NXT(a_frame_wraps, clk, rst_n, in_xfer && frame_end,
                    col_reg == '0 && row_reg == '0)

endmodule

[bench/integral_image_stream_tb.sv]
// ----------------------------------------------------------------------------
// Integral image stream testbench
// Drives raster pixels with random bursts and output stalls and predicts every
// summed-area value and end-of-frame mark. Covers frame size changes between
// frames and mid-frame, clamped and zero sizes, the widest row, a long output
// hold-off and random frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integral_image_stream_tb;

    localparam int unsigned MAX_W         = iis_pkg::DEF_MAX_WIDTH;
    localparam int unsigned MAX_H         = iis_pkg::DEF_MAX_HEIGHT;
    localparam int unsigned RANDOM_ITEMS  = 60;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned SHOWN_ERRORS  = 10;

    typedef struct packed {
        logic [iis_pkg::SUM_W-1:0] sum;
        logic                      last;
    } area_result_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic [iis_pkg::PIX_W-1:0]     pixel_value = '0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic [iis_pkg::SUM_W-1:0]     area_sum;
    logic                          frame_last;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [iis_pkg::CFG_IDX_W-1:0] cfg_index   = iis_pkg::REG_FRAME_WIDTH;
    logic [iis_pkg::CFG_W-1:0]     cfg_data    = '0;

    // predicted state of the block
    logic [iis_pkg::CFG_W-1:0]   width_reg  = iis_pkg::RST_FRAME_WIDTH;
    logic [iis_pkg::CFG_W-1:0]   height_reg = iis_pkg::RST_FRAME_HEIGHT;
    logic [17:0]                 row_sum    = '0;
    logic [iis_pkg::SUM_W-1:0]   line_sums [MAX_W];
    int unsigned                 col_idx      = 0;
    int unsigned                 row_idx      = 0;
    int unsigned                 prev_row_len = 0;

    area_result_t       pending_sums [$];

    int unsigned        err_count    = 0;
    int unsigned        idle_cycles  = 0;
    int unsigned        burst_left   = 0;
    bit                 steady       = 1'b0;
    int unsigned        hold_cycles_left = 0;
    int unsigned        pattern_left = 0;
    int unsigned        stall_mode   = 0;

    integral_image_stream dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .area_sum    (area_sum),
        .frame_last  (frame_last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // zero reads as one, oversize reads as the maximum
    function automatic int unsigned extent(input logic [iis_pkg::CFG_W-1:0] v,
                                           input int unsigned maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic int unsigned frame_remaining();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        w = extent(width_reg, MAX_W);
        h = extent(height_reg, MAX_H);
        n = (col_idx >= w - 1) ? 1 : w - col_idx;
        if (row_idx < h - 1)
            n += (h - 1 - row_idx) * w;
        return n;
    endfunction

    function automatic logic [iis_pkg::PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return iis_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [iis_pkg::CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return iis_pkg::CFG_W'(1);
            2:       return iis_pkg::CFG_W'($urandom_range(MAX_W + 1, 2047));
            3:       return iis_pkg::CFG_W'(MAX_W);
            4, 5:    return iis_pkg::CFG_W'($urandom_range(17, 100));
            default: return iis_pkg::CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    // one pixel through the summed-area recurrence
    function automatic void integrate_pixel(input logic [iis_pkg::PIX_W-1:0] pix);
        int unsigned               w;
        int unsigned               h;
        logic [iis_pkg::SUM_W-1:0] above;
        area_result_t              res;
        w = extent(width_reg, MAX_W);
        h = extent(height_reg, MAX_H);
        if (col_idx == 0)
            row_sum = '0;
        row_sum = row_sum + 18'(pix);
        above = (row_idx != 0) ? line_sums[col_idx] : '0;
        res.sum = above + iis_pkg::SUM_W'(row_sum);
        res.last = 1'b0;
        line_sums[col_idx] = res.sum;
        if (col_idx >= w - 1)
        begin
            prev_row_len = col_idx + 1;
            col_idx = 0;
            if (row_idx >= h - 1)
            begin
                row_idx = 0;
                prev_row_len = 0;
                res.last = 1'b1;
            end
            else
                row_idx++;
        end
        else
            col_idx++;
        pending_sums.push_back(res);
    endfunction

    function automatic void log_mismatch(input string what, input int exp_v, input int act_v);
        err_count++;
        if (err_count <= SHOWN_ERRORS)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endfunction

    // result check and watchdog
    always @(posedge clk)
    begin
        area_result_t exp_r;
        bit           moved;
        if (rst_n)
        begin
            moved = (in_valid && in_stall === 1'b0);
            if (out_valid === 1'b1 && !out_stall)
            begin
                moved = 1'b1;
                if (pending_sums.size() == 0)
                    log_mismatch("unexpected result, area_sum", -1, int'(area_sum));
                else
                begin
                    exp_r = pending_sums.pop_front();
                    if (area_sum !== exp_r.sum)
                        log_mismatch("area_sum", int'(exp_r.sum), int'(area_sum));
                    if (frame_last !== exp_r.last)
                        log_mismatch("frame_last", int'(exp_r.last), int'(frame_last));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("integral_image_stream_tb: done, errors");
                $finish;
            end
        end
    end

    // output stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles_left != 0)
        begin
            out_stall <= 1'b1;
            hold_cycles_left--;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 128);
            end
            pattern_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // entered and left at a falling edge; valid stays high for the next transfer
    task automatic send_pixel(input logic [iis_pkg::PIX_W-1:0] pix);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        integrate_pixel(pix);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input iis_pkg::cfg_reg_t idx,
                             input logic [iis_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == iis_pkg::REG_FRAME_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(negedge clk);
    endtask

    // only with nothing in flight
    task automatic program_dims(input bit set_w, input logic [iis_pkg::CFG_W-1:0] w,
                                input bit set_h, input logic [iis_pkg::CFG_W-1:0] h);
        wait_for_results();
        if (set_w)
            write_reg(iis_pkg::REG_FRAME_WIDTH, w);
        if (set_h)
            write_reg(iis_pkg::REG_FRAME_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_dims();
        send_pixel('0);
        send_pixel('1);
        send_pixel(8'h5a);
    endtask

    // counters carry over; the row and the frame end on the new sizes
    task automatic test_midframe_resize();
        program_dims(1'b1, iis_pkg::CFG_W'(5), 1'b1, iis_pkg::CFG_W'(3));
        send_pixel('1);
        send_pixel(8'h01);
        repeat (5) send_pixel(8'hfe);
        program_dims(1'b0, '0, 1'b1, iis_pkg::CFG_W'(2));
        send_pixel('0);
        send_pixel(8'h80);
        send_pixel('1);
        send_pixel(8'h7f);
        send_pixel('1);
    endtask

    // zero sizes act as one: every pixel is a whole frame
    task automatic test_zero_dims();
        program_dims(1'b1, '0, 1'b1, '0);
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
    endtask

    task automatic test_clamped_dims();
        program_dims(1'b1, '1, 1'b1, '1);
        repeat (3) send_pixel('1);
        program_dims(1'b1, iis_pkg::CFG_W'(3), 1'b0, '0);
        send_pixel(8'h33);
        program_dims(1'b0, '0, 1'b1, iis_pkg::CFG_W'(1));
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
    endtask

    // full-width row of saturated pixels, then a short second row
    task automatic test_widest_row();
        program_dims(1'b1, iis_pkg::CFG_W'(MAX_W), 1'b1, iis_pkg::CFG_W'(2));
        repeat (MAX_W) send_pixel('1);
        repeat (8) send_pixel('1);
        program_dims(1'b1, iis_pkg::CFG_W'(9), 1'b0, '0);
        send_pixel('1);
    endtask

    // hold the output while pixels keep coming, then pause until all are back
    task automatic test_backpressure();
        program_dims(1'b1, iis_pkg::CFG_W'(7), 1'b1, iis_pkg::CFG_W'(4));
        steady = 1'b1;
        hold_cycles_left = HOLD_CYCLES;
        repeat (40) send_pixel(pick_pixel());
        steady = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int unsigned               sent;
        int unsigned               n;
        bit                        set_w;
        bit                        set_h;
        logic [iis_pkg::CFG_W-1:0] w;
        logic [iis_pkg::CFG_W-1:0] h;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                set_w = 1'($urandom_range(0, 1));
                set_h = 1'($urandom_range(0, 1));
                if (!set_w && !set_h)
                    set_w = 1'b1;
                w = pick_dim();
                // past the first row, never widen beyond what the line store holds
                if (row_idx != 0 && extent(w, MAX_W) > prev_row_len)
                    w = iis_pkg::CFG_W'($urandom_range(1, prev_row_len));
                h = pick_dim();
                program_dims(set_w, w, set_h, h);
            end
            steady = ($urandom_range(0, 4) == 0);
            n = $urandom_range(0, 1) ? frame_remaining() : $urandom_range(1, 60);
            if (n > 200)
                n = $urandom_range(1, 60);
            repeat (n) send_pixel(pick_pixel());
            sent += n;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_dims();
        test_midframe_resize();
        test_zero_dims();
        test_clamped_dims();
        test_widest_row();
        test_backpressure();
        test_random_frames();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_sums.size() != 0)
            log_mismatch("results outstanding", 0, pending_sums.size());
        if (err_count == 0)
            $display("integral_image_stream_tb: done, clean");
        else
            $display("integral_image_stream_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/iis_pkg.sv
hdl/iis_line_store.sv
hdl/integral_image_stream.sv
bench/integral_image_stream_tb.sv
